[design/mbp_pkg.sv]
// Shared types and constants for the MSB-first bit packer.
`default_nettype none
package mbp_pkg;

  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 6;
  localparam int BYTE_W      = 8;
  localparam int EXT_W       = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_RAW = 1'b1;

  typedef struct packed {
    logic               command;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              error;
  } out_t;

  // Classified word held in the queue between the front and the back.
  typedef struct packed {
    logic               raw;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } qent_t;

  // Write side of the queue as driven by the front.
  typedef struct packed {
    logic  wr_en;
    qent_t wr_data;
  } qwr_t;

endpackage
`default_nettype wire

[design/msb_first_bit_packer_unit.sv]
// Top level of the MSB-first bit packer: front, queue and back wired together.
`default_nettype none
// This unit packs variable-length fields into a byte stream, most significant
// bit first, and also passes raw bytes through when the stream is byte
// aligned. Words enter through a queue-style port (push/full) and results
// leave through another (empty/pop); each result carries one byte, a last
// flag on the final result of its input word, and an error flag when a raw
// byte was asked for while the partial byte was not empty. The front saturates
// the count to VALUE_BITS and drops put-bits words with nothing to append, so
// those cost no time in the back. A four-entry queue separates the front from
// the back, so new words are accepted while earlier ones are still being
// packed or their results wait to be popped. The back packer is the rate
// limit: it moves up to one byte's worth of bits per cycle when not stalled.
// A full output register stalls only the cycles that would produce a result,
// that is a completed byte or a raw word. Up to (7 + VALUE_BITS) / 8 results
// follow one word; value bits above VALUE_BITS are ignored.
module msb_first_bit_packer_unit #(
  parameter int VALUE_BITS = 32
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             full,
  input  mbp_pkg::in_t     item,
  output logic             empty,
  input  wire              pop,
  output mbp_pkg::out_t    result
);
  import mbp_pkg::*;

  qwr_t  q_wr;
  logic  q_full;
  logic  q_valid;
  qent_t q_head;
  logic  q_pop;

  mbp_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .full   (full),
    .wr     (q_wr)
  );

  mbp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_data  (q_head),
    .rd_en    (q_pop)
  );

  // The back works on the queue head in place and pops it once the word is
  // fully packed.
  mbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .head_pop   (q_pop),
    .empty      (empty),
    .result     (result),
    .pop        (pop)
  );

endmodule
`default_nettype wire

[design/mbp_queue.sv]
// Small queue that decouples the classifying front from the packing back.
`default_nettype none
module mbp_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  mbp_pkg::qwr_t       wr,
  output logic                full,
  output logic                rd_valid,
  output mbp_pkg::qent_t      rd_data,
  input  wire                 rd_en
);
  import mbp_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  qent_t         mem [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;

  logic do_wr;
  logic do_rd;

  assign full     = (fill == (AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr.wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + (AW+1)'(1);
        2'b01:   fill <= fill - (AW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

[design/mbp_front.sv]
// Input side: accepts words, saturates the count and drops empty put-bits words.
`default_nettype none
module mbp_front #(
  parameter int VALUE_BITS = 32
) (
  input  wire               push,
  input  mbp_pkg::in_t      item,
  input  wire               q_full,
  output logic              full,
  output mbp_pkg::qwr_t     wr
);
  import mbp_pkg::*;

  localparam logic [COUNT_W:0] SAT = (COUNT_W+1)'(VALUE_BITS);

  logic [COUNT_W-1:0] count_sat;
  logic               is_raw;

  assign full   = q_full;
  assign is_raw = (item.command == CMD_RAW);

  always_comb begin
    if ({1'b0, item.count} > SAT) begin
      count_sat = SAT[COUNT_W-1:0];
    end else begin
      count_sat = item.count;
    end
  end

  // A put-bits word with nothing to append never reaches the back.
  assign wr.wr_en         = push && !q_full && (is_raw || (count_sat != '0));
  assign wr.wr_data.raw   = is_raw;
  assign wr.wr_data.value = item.value;
  assign wr.wr_data.count = count_sat;

endmodule
`default_nettype wire

[design/mbp_back.sv]
// Packing side: moves up to one byte's worth of bits per cycle unless stalled, and holds the result register.
`default_nettype none
module mbp_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               head_valid,
  input  mbp_pkg::qent_t    head,
  output logic              head_pop,
  output logic              empty,
  output mbp_pkg::out_t     result,
  input  wire               pop
);
  import mbp_pkg::*;

  logic [BYTE_W-1:0]  partial;
  logic [2:0]         pos;
  logic               started;
  logic [COUNT_W-1:0] rem;
  logic               out_valid;
  out_t               out_reg;

  logic [COUNT_W-1:0] r;
  logic [3:0]         avail;
  logic [3:0]         k;
  logic [COUNT_W-1:0] s;
  logic [EXT_W-1:0]   vext;
  logic [BYTE_W-1:0]  window;
  logic [BYTE_W:0]    mask9;
  logic [BYTE_W-1:0]  placed;
  logic [BYTE_W-1:0]  new_partial;
  logic [3:0]         new_pos;
  logic               emits;
  logic               can_emit;
  logic               go;
  logic               done;

  assign r     = started ? rem : head.count;
  assign avail = 4'd8 - {1'b0, pos};
  assign k     = (r < {2'b00, avail}) ? r[3:0] : avail;
  assign s     = r - {2'b00, k};
  assign vext  = {{(EXT_W-VALUE_W){1'b0}}, head.value};

  always_comb begin
    window      = BYTE_W'(vext >> s);
    mask9       = ((BYTE_W+1)'(1) << k) - (BYTE_W+1)'(1);
    placed      = (window & mask9[BYTE_W-1:0]) << (avail[2:0] - k[2:0]);
    new_partial = partial | placed;
    new_pos     = {1'b0, pos} + k;
  end

  assign emits    = head.raw || (new_pos == 4'd8);
  assign can_emit = !out_valid || pop;
  assign go       = head_valid && (!emits || can_emit);
  assign done     = head.raw || (s == '0);
  assign head_pop = go && done;

  assign empty  = !out_valid;
  assign result = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial   <= '0;
      pos       <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (go && emits) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      if (go) begin
        started <= !done;
        if (!head.raw) begin
          if (new_pos == 4'd8) begin
            partial <= '0;
            pos     <= '0;
          end else begin
            partial <= new_partial;
            pos     <= new_pos[2:0];
          end
        end
      end
    end
  end

  // The result register only changes when a byte is actually emitted, so a
  // waiting result is never disturbed by cycles that just collect bits.
  always_ff @(posedge clk) begin
    if (go) begin
      rem <= s;
    end
    if (go && emits) begin
      if (head.raw) begin
        out_reg.out_byte <= (pos == '0) ? head.value[BYTE_W-1:0] : '0;
        out_reg.last     <= 1'b1;
        out_reg.error    <= (pos != '0);
      end else begin
        // No further byte can complete once fewer than eight bits remain.
        out_reg.out_byte <= new_partial;
        out_reg.last     <= (s < COUNT_W'(BYTE_W));
        out_reg.error    <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_raw_keeps_position: assert property (@(posedge clk) disable iff (rst)
    (go && head.raw) |=> (pos == $past(pos) && partial == $past(partial)))
    else $error("raw word changed the bit position");

  a_started_needs_head: assert property (@(posedge clk) disable iff (rst)
    started |-> (head_valid && !head.raw))
    else $error("partly packed word vanished from the queue head");

  a_emit_fills_result: assert property (@(posedge clk) disable iff (rst)
    (go && emits) |=> out_valid)
    else $error("emitted byte not presented");

  a_error_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.error) |-> (out_reg.last && out_reg.out_byte == '0))
    else $error("error result carries data");
`endif

endmodule
`default_nettype wire
